@@ hdl/rrm_pkg.sv @@
`timescale 1ns / 1ps

package rrm_pkg;

	// Register file geometry.
	localparam int RF_DEPTH = 64;
	localparam int RF_AW    = 6;

	// Register numbers with behavior of their own.
	localparam logic [RF_AW-1:0] REG_COMMAND    = 6'h01;
	localparam logic [RF_AW-1:0] REG_IRQ        = 6'h04;
	localparam logic [RF_AW-1:0] REG_FIFO_DATA  = 6'h09;
	localparam logic [RF_AW-1:0] REG_FIFO_LEVEL = 6'h0A;
	localparam logic [RF_AW-1:0] REG_CONTROL    = 6'h0C;
	localparam logic [RF_AW-1:0] REG_FRAMING    = 6'h0D;
	localparam logic [RF_AW-1:0] REG_VERSION    = 6'h37;

	// Fixed values.
	localparam logic [7:0] VERSION_ID     = 8'h92;
	localparam logic [3:0] OPC_TRANSCEIVE = 4'hC;
	localparam logic [3:0] OPC_SOFT_RESET = 4'hF;
	localparam logic [7:0] CARD_REQA      = 8'h26;
	localparam logic [7:0] CARD_ANTICOLL  = 8'h93;
	localparam logic [7:0] ATQA_LO        = 8'h44;
	localparam logic [7:0] IRQ_TIMER      = 8'h01;
	localparam logic [7:0] IRQ_RX_IDLE    = 8'h30;
	localparam logic [2:0] REQA_LAST     = 3'd1;
	localparam logic [2:0] ANTICOLL_LAST = 3'd4;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_TRX,
		ST_LOAD,
		ST_RESP
	} state_t;

	// Datapath operation for the current cycle.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_ISSUE,
		OP_TRX,
		OP_LOAD,
		OP_RESP
	} dp_op_t;

	// Source of the read byte.
	typedef enum logic [1:0] {
		RS_DIRECT,
		RS_RFMEM,
		RS_FIFO
	} rsel_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_trx;
		logic trx_load;
		logic load_last;
		logic out_busy;
	} dp_status_t;

	// Value a register holds after reset or soft reset.
	function automatic logic [7:0] rf_reset_value(input logic [RF_AW-1:0] num);
		logic [7:0] val;
		val = (num == REG_VERSION) ? VERSION_ID : 8'h00;
		return val;
	endfunction

endpackage

@@ hdl/rrm_ctrl.sv @@
`timescale 1ns / 1ps

module rrm_ctrl import rrm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				state_nxt = sts.is_trx ? ST_TRX : ST_RESP;
			end
			ST_TRX: begin
				state_nxt = sts.trx_load ? ST_LOAD : ST_RESP;
			end
			ST_LOAD: begin
				if (sts.load_last) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!sts.out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.op      = OP_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_ISSUE: cmd.op = OP_ISSUE;
			ST_TRX:   cmd.op = OP_TRX;
			ST_LOAD:  cmd.op = OP_LOAD;
			ST_RESP:  cmd.op = OP_RESP;
			default:  cmd.op = OP_IDLE;
		endcase
	end

endmodule

@@ hdl/rrm_datapath.sv @@
`timescale 1ns / 1ps

module rrm_datapath import rrm_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  sts,
	input  logic [7:0]  address_byte,
	input  logic [7:0]  write_byte,
	input  logic        short_transfer,
	input  logic        card_present,
	input  logic [31:0] card_uid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data
);

	localparam int PW = $clog2(FIFO_DEPTH + 1);
	localparam int AW = $clog2(FIFO_DEPTH);

	// Captured access.
	logic [7:0]  addr_q;
	logic [7:0]  wdata_q;
	logic        short_q;
	logic        present_q;
	logic [31:0] uid_q;

	// Architectural state.
	logic [3:0]          cmd_reg_q;
	logic [7:0]          irq_q;
	logic [7:0]          ctl_q;
	logic [PW-1:0]       lvl_q;
	logic [PW-1:0]       wp_q;
	logic [PW-1:0]       rp_q;
	logic [31:0]         saved_uid_q;
	logic [RF_DEPTH-1:0] vld_q;

	logic [7:0] rf_mem [RF_DEPTH];
	logic [7:0] fifo_mem [FIFO_DEPTH];
	logic [7:0] rf_rd_q;
	logic [7:0] fifo_rd_q;

	// Transceive loader and result selection.
	logic [2:0] cnt_q;
	logic       anti_q;
	rsel_t      rsel_q;
	logic [7:0] direct_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;

	logic [RF_AW-1:0] reg_num;
	logic             is_read;
	logic             is_write;
	logic             pop_ok;
	logic             push_ok;
	logic             special;
	logic             rf_we;
	logic             fifo_we;
	logic [AW-1:0]    fifo_wa;
	logic [AW-1:0]    fifo_ra;
	logic [7:0]       fifo_wd;
	logic [7:0]       load_byte;
	logic [7:0]       uid_xor;
	logic [7:0]       special_val;
	logic [7:0]       resp_byte;
	logic             trx_hit;

	// Access decode.
	assign reg_num  = addr_q[6:1];
	assign is_read  = !short_q && addr_q[7];
	assign is_write = !short_q && !addr_q[7];
	assign pop_ok   = rp_q < wp_q;
	assign push_ok  = wp_q < PW'(FIFO_DEPTH);
	assign special  = (reg_num == REG_COMMAND) || (reg_num == REG_IRQ) ||
		(reg_num == REG_FIFO_DATA) || (reg_num == REG_FIFO_LEVEL) ||
		(reg_num == REG_CONTROL);
	assign trx_hit  = (fifo_rd_q == CARD_REQA) || (fifo_rd_q == CARD_ANTICOLL);

	assign sts.is_trx    = is_write && (reg_num == REG_FRAMING) && wdata_q[7] &&
		(cmd_reg_q == OPC_TRANSCEIVE);
	assign sts.trx_load  = (wp_q != '0) && present_q && trx_hit;
	assign sts.load_last = cnt_q == (anti_q ? ANTICOLL_LAST : REQA_LAST);
	assign sts.out_busy  = out_valid_q && !out_ready;

	// Values of registers held in flops.
	always_comb begin
		unique case (reg_num)
			REG_COMMAND:    special_val = {4'h0, cmd_reg_q};
			REG_IRQ:        special_val = irq_q;
			REG_FIFO_LEVEL: special_val = 8'(lvl_q);
			REG_CONTROL:    special_val = ctl_q;
			default:        special_val = 8'h00;
		endcase
	end

	// Bytes written back into the FIFO by a transceive.
	assign uid_xor = saved_uid_q[7:0] ^ saved_uid_q[15:8] ^ saved_uid_q[23:16] ^
		saved_uid_q[31:24];

	always_comb begin
		if (anti_q) begin
			unique case (cnt_q)
				3'd0:    load_byte = saved_uid_q[7:0];
				3'd1:    load_byte = saved_uid_q[15:8];
				3'd2:    load_byte = saved_uid_q[23:16];
				3'd3:    load_byte = saved_uid_q[31:24];
				default: load_byte = uid_xor;
			endcase
		end else begin
			load_byte = (cnt_q == 3'd0) ? ATQA_LO : 8'h00;
		end
	end

	// Memory port controls.
	assign rf_we   = (cmd.op == OP_ISSUE) && is_write && !special;
	assign fifo_we = ((cmd.op == OP_ISSUE) && is_write && (reg_num == REG_FIFO_DATA) &&
		push_ok) || (cmd.op == OP_LOAD);
	assign fifo_wa = (cmd.op == OP_LOAD) ? AW'(cnt_q) : wp_q[AW-1:0];
	assign fifo_wd = (cmd.op == OP_LOAD) ? load_byte : wdata_q;
	assign fifo_ra = sts.is_trx ? '0 : rp_q[AW-1:0];

	// Register file memory.
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[reg_num] <= wdata_q;
		end
		if (cmd.op == OP_ISSUE) begin
			rf_rd_q <= rf_mem[reg_num];
		end
	end

	// FIFO memory.
	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[fifo_wa] <= fifo_wd;
		end
		if (cmd.op == OP_ISSUE) begin
			fifo_rd_q <= fifo_mem[fifo_ra];
		end
	end

	// Input capture and payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q    <= address_byte;
			wdata_q   <= write_byte;
			short_q   <= short_transfer;
			present_q <= card_present;
			uid_q     <= card_uid;
		end
		if (cmd.op == OP_ISSUE) begin
			// Flop-held registers and an empty FIFO answer with a direct byte.
			direct_q <= (is_read && special) ? special_val : 8'h00;
			if (!is_read) begin
				rsel_q <= RS_DIRECT;
			end else if (reg_num == REG_FIFO_DATA) begin
				rsel_q <= pop_ok ? RS_FIFO : RS_DIRECT;
			end else if (special) begin
				rsel_q <= RS_DIRECT;
			end else begin
				rsel_q <= RS_RFMEM;
			end
		end
		if (cmd.op == OP_TRX) begin
			cnt_q  <= 3'd0;
			anti_q <= fifo_rd_q == CARD_ANTICOLL;
		end else if (cmd.op == OP_LOAD) begin
			cnt_q <= cnt_q + 3'd1;
		end
		if ((cmd.op == OP_RESP) && !sts.out_busy) begin
			out_data_q <= resp_byte;
		end
	end

	// Architectural register and pointer updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_reg_q   <= '0;
			irq_q       <= '0;
			ctl_q       <= '0;
			lvl_q       <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			saved_uid_q <= '0;
			vld_q       <= '0;
		end else begin
			if ((cmd.op == OP_ISSUE) && is_read) begin
				if ((reg_num == REG_FIFO_DATA) && pop_ok) begin
					rp_q <= rp_q + PW'(1);
					if (lvl_q != '0) begin
						lvl_q <= lvl_q - PW'(1);
					end
				end
			end else if ((cmd.op == OP_ISSUE) && is_write) begin
				unique case (reg_num)
					REG_COMMAND: begin
						if (wdata_q[3:0] == OPC_SOFT_RESET) begin
							cmd_reg_q <= '0;
							irq_q     <= '0;
							ctl_q     <= '0;
							lvl_q     <= '0;
							wp_q      <= '0;
							rp_q      <= '0;
							vld_q     <= '0;
						end else begin
							cmd_reg_q <= wdata_q[3:0];
						end
					end
					REG_FIFO_DATA: begin
						if (push_ok) begin
							wp_q  <= wp_q + PW'(1);
							lvl_q <= wp_q + PW'(1);
						end
					end
					REG_FIFO_LEVEL: begin
						if (wdata_q[7]) begin
							wp_q  <= '0;
							rp_q  <= '0;
							lvl_q <= '0;
						end
					end
					REG_IRQ:     irq_q <= wdata_q;
					REG_CONTROL: ctl_q <= wdata_q;
					default:     vld_q[reg_num] <= 1'b1;
				endcase
			end else if (cmd.op == OP_TRX) begin
				// Empty FIFO only raises the timer flag; otherwise the FIFO is consumed.
				if (wp_q == '0) begin
					irq_q <= irq_q | IRQ_TIMER;
				end else begin
					rp_q <= '0;
					if (!present_q || !trx_hit) begin
						wp_q  <= '0;
						irq_q <= irq_q | IRQ_TIMER;
					end else if (fifo_rd_q == CARD_REQA) begin
						wp_q        <= PW'(2);
						lvl_q       <= PW'(2);
						ctl_q       <= '0;
						irq_q       <= irq_q | IRQ_RX_IDLE;
						saved_uid_q <= uid_q;
					end else begin
						wp_q  <= PW'(5);
						lvl_q <= PW'(5);
						ctl_q <= '0;
						irq_q <= irq_q | IRQ_RX_IDLE;
					end
				end
			end
		end
	end

	// Read byte for the response.
	always_comb begin
		unique case (rsel_q)
			RS_RFMEM: resp_byte = vld_q[reg_num] ? rf_rd_q : rf_reset_value(reg_num);
			RS_FIFO:  resp_byte = fifo_rd_q;
			default:  resp_byte = direct_q;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.op == OP_RESP) && !sts.out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;

	// The read pointer never passes the write pointer.
	a_rp_le_wp: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= wp_q)
		else $error("FIFO read pointer ahead of write pointer");

	// The write pointer never passes the FIFO depth.
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PW'(FIFO_DEPTH))
		else $error("FIFO write pointer beyond depth");

	// The loader stays within the answer it is writing.
	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (cnt_q <= (anti_q ? ANTICOLL_LAST : REQA_LAST)))
		else $error("transceive loader ran past its answer");

	// A new word is only presented out of the response step.
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.op == OP_RESP))
		else $error("output word raised outside the response step");

endmodule

@@ hdl/rfid_reader_register_model.sv @@
`timescale 1ns / 1ps
// Steps: an access is captured in idle, issued, then answered from the response step; a
// transceive adds a TRX step, and a card answer to REQA or anticollision adds LOAD steps.
// A new access is taken only in idle, after the last one is answered; the controller steps
// and the single FIFO write port set the pace, and a waiting word holds the next response.
// Reset: arst_n clears the controller, pointers and flag registers at once; the register
// file reads as its reset values through per-entry valid bits, with no clearing pass.

module rfid_reader_register_model import rrm_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// address_byte [7:0], write_byte [15:8], short_transfer [16], card_present [17],
	// card_uid [49:18], zero fill [55:50]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data [7:0]
	output logic [7:0]  m_tdata
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	rrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrm_datapath #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.address_byte   (s_tdata[7:0]),
		.write_byte     (s_tdata[15:8]),
		.short_transfer (s_tdata[16]),
		.card_present   (s_tdata[17]),
		.card_uid       (s_tdata[49:18]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.read_data      (m_tdata)
	);

endmodule

@@ tb/tb_rfid_reader_register_model.sv @@
`timescale 1ns / 1ps

module tb_rfid_reader_register_model import rrm_pkg::*; ();

	localparam int FIFO_SIZE     = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int TARGET_WORDS  = 390;
	localparam int TAIL_CYCLES   = 20;
	localparam int REPORT_LIMIT  = 10;

	// Bit masks with a meaning of their own in the access protocol.
	localparam logic [7:0] ADDR_READ     = 8'h80;
	localparam logic [7:0] FIFO_FLUSH    = 8'h80;
	localparam logic [7:0] FRAMING_START = 8'h80;
	localparam logic [7:0] CMD_FIELD     = 8'h0F;

	// One SPI access as it travels on the input stream.
	typedef struct packed {
		logic [31:0] card_uid;
		logic        card_present;
		logic        short_transfer;
		logic [7:0]  write_byte;
		logic [7:0]  address_byte;
	} spi_access_t;

	// Shadow copy of the reader registers and FIFO, plus the bytes still owed.
	class reader_shadow;
		logic [7:0]  regs [RF_DEPTH];
		logic [7:0]  fifo_mem [FIFO_SIZE];
		logic [6:0]  wr_ptr;
		logic [6:0]  rd_ptr;
		logic [31:0] uid_latch;
		logic [7:0]  pending_bytes [$];
		int          error_count;

		function new();
			clear_registers();
			foreach (fifo_mem[i]) fifo_mem[i] = 8'h00;
			uid_latch   = '0;
			error_count = 0;
		endfunction

		// Power-on and soft reset state; the captured UID survives a soft reset.
		function void clear_registers();
			foreach (regs[i]) regs[i] = (i == REG_VERSION) ? VERSION_ID : 8'h00;
			wr_ptr = '0;
			rd_ptr = '0;
		endfunction

		// Card exchange started from the bit-framing register.
		function void run_transceive(logic present, logic [31:0] uid);
			logic [7:0] picc_cmd;
			if (wr_ptr == 0) begin
				regs[REG_IRQ] |= IRQ_TIMER;
				return;
			end
			picc_cmd = fifo_mem[0];
			wr_ptr = '0;
			rd_ptr = '0;
			if (!present) begin
				regs[REG_IRQ] |= IRQ_TIMER;
			end else if (picc_cmd == CARD_REQA) begin
				fifo_mem[0] = ATQA_LO;
				fifo_mem[1] = 8'h00;
				wr_ptr = 7'd2;
				regs[REG_FIFO_LEVEL] = 8'd2;
				regs[REG_CONTROL] = 8'h00;
				regs[REG_IRQ] |= IRQ_RX_IDLE;
				uid_latch = uid;
			end else if (picc_cmd == CARD_ANTICOLL) begin
				fifo_mem[0] = uid_latch[7:0];
				fifo_mem[1] = uid_latch[15:8];
				fifo_mem[2] = uid_latch[23:16];
				fifo_mem[3] = uid_latch[31:24];
				fifo_mem[4] = uid_latch[7:0] ^ uid_latch[15:8] ^ uid_latch[23:16] ^
					uid_latch[31:24];
				wr_ptr = 7'd5;
				regs[REG_FIFO_LEVEL] = 8'd5;
				regs[REG_CONTROL] = 8'h00;
				regs[REG_IRQ] |= IRQ_RX_IDLE;
			end else begin
				regs[REG_IRQ] |= IRQ_TIMER;
			end
		endfunction

		// Applies one access and returns the byte it reads back.
		function logic [7:0] predict(spi_access_t a);
			logic [RF_AW-1:0] num;
			logic [7:0]       val;
			logic [7:0]       rd_byte;
			num     = a.address_byte[6:1];
			val     = a.write_byte;
			rd_byte = 8'h00;
			if (a.short_transfer) return rd_byte;
			if (a.address_byte & ADDR_READ) begin
				if (num != REG_FIFO_DATA) return regs[num];
				if (rd_ptr < wr_ptr) begin
					rd_byte = fifo_mem[rd_ptr[5:0]];
					rd_ptr++;
					if (regs[REG_FIFO_LEVEL] != 0) regs[REG_FIFO_LEVEL]--;
				end
				return rd_byte;
			end
			unique case (num)
				REG_COMMAND: begin
					regs[num] = val & CMD_FIELD;
					if ((val & CMD_FIELD) == OPC_SOFT_RESET) clear_registers();
				end
				REG_FIFO_DATA: begin
					if (wr_ptr < FIFO_SIZE) begin
						fifo_mem[wr_ptr[5:0]] = val;
						wr_ptr++;
						regs[REG_FIFO_LEVEL] = {1'b0, wr_ptr};
					end
				end
				REG_FIFO_LEVEL: begin
					if (val & FIFO_FLUSH) begin
						wr_ptr = '0;
						rd_ptr = '0;
						regs[REG_FIFO_LEVEL] = 8'h00;
					end
				end
				default: begin
					regs[num] = val;
					if (num == REG_FRAMING && (val & FRAMING_START) &&
							regs[REG_COMMAND] == {4'h0, OPC_TRANSCEIVE})
						run_transceive(a.card_present, a.card_uid);
				end
			endcase
			return rd_byte;
		endfunction

		function void note_access(spi_access_t a);
			pending_bytes.push_back(predict(a));
		endfunction

		function void check_read_byte(logic [7:0] got);
			logic [7:0] want;
			if (pending_bytes.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("read word 0x%02h arrived with nothing pending", got);
				return;
			end
			want = pending_bytes.pop_front();
			if (got !== want) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("read_data mismatch: expected 0x%02h, got 0x%02h", want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// address_byte [7:0], write_byte [15:8], short_transfer [16], card_present [17],
	// card_uid [49:18], zero fill [55:50]
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// read_data [7:0]
	logic [7:0]  m_tdata;

	reader_shadow shadow;
	int           accepted_inputs;
	bit           steady;
	bit           hold_done;
	bit           drained;

	rfid_reader_register_model #(
		.FIFO_DEPTH(FIFO_SIZE)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one, none during steady stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one word and waits until the block takes it.
	task automatic send_access(input spi_access_t a);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {6'b0, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		shadow.note_access(a);
		accepted_inputs++;
	endtask

	task automatic access_reg(input logic rd, input logic [5:0] num, input logic [7:0] val,
			input logic present, input logic [31:0] uid);
		spi_access_t a;
		a.address_byte   = {rd, num, 1'($urandom_range(0, 1))};
		a.write_byte     = val;
		a.short_transfer = 1'b0;
		a.card_present   = present;
		a.card_uid       = uid;
		send_access(a);
	endtask

	task automatic write_reg(input logic [5:0] num, input logic [7:0] val);
		access_reg(1'b0, num, val, 1'($urandom_range(0, 1)), $urandom);
	endtask

	task automatic read_reg(input logic [5:0] num);
		access_reg(1'b1, num, 8'($urandom), 1'($urandom_range(0, 1)), $urandom);
	endtask

	task automatic random_access();
		spi_access_t a;
		a.address_byte   = 8'($urandom);
		a.write_byte     = 8'($urandom);
		a.short_transfer = ($urandom_range(0, 9) == 0);
		a.card_present   = 1'($urandom_range(0, 1));
		a.card_uid       = $urandom;
		send_access(a);
	endtask

	// A well-formed card exchange: select transceive, load a command, start, drain.
	task automatic card_exchange();
		int         r;
		logic [7:0] picc_cmd;
		logic [7:0] command_val;
		if ($urandom_range(0, 3) != 0) begin
			command_val = {4'($urandom_range(0, 15)), OPC_TRANSCEIVE};
			write_reg(REG_COMMAND, command_val);
		end
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_FIFO_LEVEL, FIFO_FLUSH | 8'($urandom_range(0, 127)));
		r = $urandom_range(0, 99);
		picc_cmd = (r < 45) ? CARD_REQA : (r < 80) ? CARD_ANTICOLL : 8'($urandom);
		write_reg(REG_FIFO_DATA, picc_cmd);
		repeat ($urandom_range(0, 2)) write_reg(REG_FIFO_DATA, 8'($urandom));
		access_reg(1'b0, REG_FRAMING, FRAMING_START | 8'($urandom_range(0, 127)),
			($urandom_range(0, 7) != 0), $urandom);
		repeat ($urandom_range(0, 6)) read_reg(REG_FIFO_DATA);
		r = $urandom_range(0, 5);
		if (r == 0) read_reg(REG_IRQ);
		else if (r == 1) read_reg(REG_FIFO_LEVEL);
		else if (r == 2) read_reg(REG_CONTROL);
	endtask

	// Fills the FIFO to near or past its depth, so that any pushes beyond it are dropped.
	task automatic fill_fifo_run();
		write_reg(REG_FIFO_LEVEL, FIFO_FLUSH);
		repeat ($urandom_range(FIFO_SIZE - 2, FIFO_SIZE + 3)) write_reg(REG_FIFO_DATA, 8'($urandom));
		read_reg(REG_FIFO_LEVEL);
		repeat ($urandom_range(0, 8)) read_reg(REG_FIFO_DATA);
	endtask

	// Stimulus and end of run.
	initial begin
		int         pick;
		logic [5:0] num;
		logic [7:0] command_val;
		spi_access_t a;
		shadow          = new();
		accepted_inputs = 0;
		steady          = 1'b0;
		drained         = 1'b0;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: reset values, register extremes, each exchange outcome.
		read_reg(REG_VERSION);
		read_reg(REG_FIFO_DATA);
		write_reg(6'h3F, 8'hFF);
		read_reg(6'h3F);
		write_reg(REG_FRAMING, FRAMING_START);
		command_val = {4'hF, OPC_TRANSCEIVE};
		write_reg(REG_COMMAND, command_val);
		access_reg(1'b0, REG_FRAMING, FRAMING_START, 1'b1, 32'h0);
		read_reg(REG_IRQ);
		write_reg(REG_FIFO_DATA, CARD_REQA);
		write_reg(REG_FIFO_LEVEL, 8'h7F);
		read_reg(REG_FIFO_LEVEL);
		access_reg(1'b0, REG_FRAMING, 8'hFF, 1'b1, 32'hFFFF_FFFF);
		repeat (3) read_reg(REG_FIFO_DATA);
		write_reg(REG_FIFO_DATA, CARD_ANTICOLL);
		access_reg(1'b0, REG_FRAMING, FRAMING_START, 1'b1, 32'h0);
		repeat (5) read_reg(REG_FIFO_DATA);
		write_reg(REG_FIFO_DATA, CARD_REQA);
		access_reg(1'b0, REG_FRAMING, FRAMING_START, 1'b0, 32'h1234_5678);
		write_reg(REG_FIFO_DATA, 8'h55);
		access_reg(1'b0, REG_FRAMING, FRAMING_START, 1'b1, 32'h0);
		read_reg(REG_IRQ);
		write_reg(REG_FIFO_DATA, 8'h00);
		write_reg(REG_FIFO_LEVEL, FIFO_FLUSH);
		read_reg(REG_FIFO_LEVEL);
		a = '{card_uid: 32'hFFFF_FFFF, card_present: 1'b1, short_transfer: 1'b1,
			write_byte: 8'hFF, address_byte: 8'hFF};
		send_access(a);
		write_reg(REG_COMMAND, 8'hFF);
		read_reg(REG_VERSION);

		// Random part: card exchanges, register write-read pairs and noise, with FIFO overflow runs.
		fill_fifo_run();
		while (accepted_inputs < TARGET_WORDS) begin
			steady = ($urandom_range(0, 5) == 0);
			if (!drained && accepted_inputs >= 250) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				while (shadow.pending_bytes.size() != 0) @(posedge clk);
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				card_exchange();
			end else if (pick < 43) begin
				fill_fifo_run();
			end else if (pick < 58) begin
				num = 6'($urandom);
				write_reg(num, 8'($urandom));
				read_reg(num);
			end else begin
				random_access();
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (shadow.pending_bytes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.error_count == 0 && shadow.pending_bytes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Result side: random back-pressure, with one long hold to fill the block.
	initial begin
		int stall;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = pick_gap();
			if (!hold_done && accepted_inputs >= 120) begin
				stall     = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			shadow.check_read_byte(m_tdata);
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
